// File: rtl/pcgs_pkg.sv
// Package: transaction types, constants and shaping functions for the contextual glyph shaper
package pcgs_pkg;

  localparam logic [15:0] JoinMin   = 16'd1000;
  localparam logic [15:0] StartFill = 16'd32;

  typedef struct packed {
    logic [15:0] char_code;
    logic        end_of_string;
  } in_t;

  typedef struct packed {
    logic [15:0] shaped_code;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] cur;
    logic [15:0] earlier;
    logic [15:0] after;
  } job_t;

  function automatic logic prev_joins(input logic [15:0] c);
    logic r;
    r = 1'b1;
    if (c < JoinMin) r = 1'b0;
    if (c == 16'd1570 || c == 16'd1575 || c == 16'd1608 || c == 16'd1688) r = 1'b0;
    if (c > 16'd1582 && c < 16'd1587) r = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] medial_base(input logic [15:0] c);
    logic [15:0] r;
    case (c)
      16'd1574: r = 16'd65164;
      16'd1576: r = 16'd65170;
      16'd1578: r = 16'd65176;
      16'd1579: r = 16'd65180;
      16'd1580: r = 16'd65184;
      16'd1581: r = 16'd65188;
      16'd1582: r = 16'd65192;
      16'd1587: r = 16'd65204;
      16'd1588: r = 16'd65208;
      16'd1589: r = 16'd65212;
      16'd1590: r = 16'd65216;
      16'd1591: r = 16'd65220;
      16'd1592: r = 16'd65224;
      16'd1593: r = 16'd65228;
      16'd1594: r = 16'd65232;
      16'd1601: r = 16'd65236;
      16'd1602: r = 16'd65240;
      16'd1604: r = 16'd65248;
      16'd1605: r = 16'd65252;
      16'd1606: r = 16'd65256;
      16'd1607: r = 16'd65260;
      16'd1662: r = 16'd64345;
      16'd1670: r = 16'd64381;
      16'd1705: r = 16'd64401;
      16'd1711: r = 16'd64405;
      default:  r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] isolated_base(input logic [15:0] c);
    logic [15:0] r;
    case (c)
      16'd1575: r = 16'd65165;
      16'd1583: r = 16'd65193;
      16'd1584: r = 16'd65195;
      16'd1585: r = 16'd65197;
      16'd1586: r = 16'd65199;
      16'd1608: r = 16'd65261;
      16'd1688: r = 16'd64394;
      default:  r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] shape(input logic [15:0] cur, input logic [15:0] earlier,
                                        input logic [15:0] after, input logic rev);
    logic [15:0] pc;
    logic [15:0] nc;
    logic        p;
    logic        n;
    logic [15:0] mb;
    logic [15:0] ib;
    logic [15:0] r;
    pc = rev ? after : earlier;
    nc = rev ? earlier : after;
    p  = prev_joins(pc);
    n  = (nc >= JoinMin);
    mb = medial_base(cur);
    ib = isolated_base(cur);
    if (cur < JoinMin) begin
      r = cur;
    end else if (mb != 16'd0) begin
      r = mb + {15'd0, p} + {14'd0, n, 1'b0} - 16'd3;
    end else if (ib != 16'd0) begin
      r = ib + {15'd0, p};
    end else if (cur == 16'd1610 || cur == 16'd1740) begin
      if (p && n) r = 16'd65268;
      else if (p) r = 16'd65264;
      else if (n) r = 16'd65267;
      else        r = 16'd65263;
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

// File: rtl/persian_contextual_glyph_shaper.sv
// Top level: contextual glyph shaper with lookahead window, shaping stage and result queue
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_data_i  (pcgs_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i  | out_data_o (pcgs_pkg::out_t)
//  cfg     | input     | cfg_we_i                   | cfg_data_i (reverse_order)
//
// One transaction is accepted per cycle while in_ready_o is high; its jobs are registered in the shaping stage.
// The window register holds one character back; the shaping stage writes up to two results
// per cycle into a four-entry result queue, which drains one result per cycle while out_ready_i is high.
// The input stalls while the queue holds more than two results and the stage is full.
// Reset (rst_ni low, asynchronous) empties the window, stage and queue and clears reverse_order.
module persian_contextual_glyph_shaper (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pcgs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pcgs_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_data_i
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  logic        rev_q;
  logic        have_q, have_d;
  logic [15:0] pend_q, pend_d;
  logic [15:0] earl_q, earl_d;

  logic           s1_valid_q, s1_valid_d;
  pcgs_pkg::job_t job0_q, job0_d;
  pcgs_pkg::job_t job1_q, job1_d;

  pcgs_pkg::out_t  queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic           accept;
  logic           adv;
  logic           pop;
  logic [15:0]    earl_mid;
  logic [15:0]    sh0;
  logic [15:0]    sh1;
  logic           push0;
  logic           push1;
  logic [PtrW-1:0] wr1_ptr;

  assign adv        = s1_valid_q && (cnt_q <= CntW'(QDepth - 2));
  assign in_ready_o = !s1_valid_q || adv;
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = queue_q[rd_ptr_q];

  // Window: build the shaping jobs and advance the lookahead state
  always_comb begin
    earl_mid = have_q ? pend_q : earl_q;
    have_d   = have_q;
    pend_d   = pend_q;
    earl_d   = earl_q;
    job0_d.valid   = have_q;
    job0_d.cur     = pend_q;
    job0_d.earlier = earl_q;
    job0_d.after   = in_data_i.char_code;
    job1_d.valid   = in_data_i.end_of_string;
    job1_d.cur     = in_data_i.char_code;
    job1_d.earlier = earl_mid;
    job1_d.after   = 16'd0;
    if (accept) begin
      if (in_data_i.end_of_string) begin
        have_d = 1'b0;
        pend_d = 16'd0;
        earl_d = pcgs_pkg::StartFill;
      end else begin
        have_d = 1'b1;
        pend_d = in_data_i.char_code;
        earl_d = earl_mid;
      end
    end
    if (accept) s1_valid_d = 1'b1;
    else if (adv) s1_valid_d = 1'b0;
    else s1_valid_d = s1_valid_q;
  end

  // Shaping stage and queue bookkeeping
  always_comb begin
    sh0     = pcgs_pkg::shape(job0_q.cur, job0_q.earlier, job0_q.after, rev_q);
    sh1     = pcgs_pkg::shape(job1_q.cur, job1_q.earlier, job1_q.after, rev_q);
    push0   = adv && job0_q.valid;
    push1   = adv && job1_q.valid;
    wr1_ptr = wr_ptr_q + PtrW'(push0);
    wr_ptr_d = wr_ptr_q + PtrW'(push0) + PtrW'(push1);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push0) + CntW'(push1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q      <= 1'b0;
      have_q     <= 1'b0;
      pend_q     <= 16'd0;
      earl_q     <= pcgs_pkg::StartFill;
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) rev_q <= cfg_data_i;
      have_q     <= have_d;
      pend_q     <= pend_d;
      earl_q     <= earl_d;
      s1_valid_q <= s1_valid_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job0_q <= job0_d;
      job1_q <= job1_d;
    end
    if (push0) queue_q[wr_ptr_q] <= '{shaped_code: sh0, last_result: 1'b0};
    if (push1) queue_q[wr1_ptr]  <= '{shaped_code: sh1, last_result: 1'b1};
  end

endmodule
